// ----- hw/rtl/jsu_pkg.sv -----
// Package with the shared types and character constants of the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int unsigned MaxRun = 6;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX    = 3'd2
  } phase_e;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] CtlBs   = 8'h08;
  localparam logic [7:0] CtlFf   = 8'h0C;
  localparam logic [7:0] CtlLf   = 8'h0A;
  localparam logic [7:0] CtlCr   = 8'h0D;
  localparam logic [7:0] CtlTab  = 8'h09;

  localparam logic [15:0] Utf8Max1 = 16'h007F;
  localparam logic [15:0] Utf8Max2 = 16'h07FF;
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;
  localparam logic [5:0] Utf8Mask  = 6'h3F;

  // One run of results caused by a single input byte. When is_end is set, the
  // last result of the run is the bare end marker.
  typedef struct packed {
    logic [2:0]        cnt;
    logic              is_end;
    logic [MaxRun-1:0][7:0] bytes;
  } run_t;

endpackage

// ----- hw/rtl/jsu_if.sv -----
// Stream interfaces for the raw input bytes and the unescaped results.
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       string_end;
  logic       last_of_run;

  modport source (output valid, output data_byte, output has_byte, output string_end,
                  output last_of_run, input ready);
  modport sink (input valid, input data_byte, input has_byte, input string_end,
                input last_of_run, output ready);
endinterface

// ----- hw/rtl/jsu_front.sv -----
// Front end: accepts raw bytes, tracks the escape state and builds one result run per byte.
`timescale 1ns / 1ps

module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_in_if.sink     in_ch_i,
  input  logic       q_full_i,
  output logic       push_o,
  output run_t       run_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  digits_q, digits_d;
  logic [15:0] accum_q, accum_d;
  logic [2:0][7:0] held_q;
  logic        accept;
  logic [7:0]  c;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;

  assign in_ch_i.ready = ~q_full_i;
  assign accept = in_ch_i.valid & ~q_full_i;
  assign c = in_ch_i.in_byte;
  assign cp = {accum_q[11:0], hex_val};

  always_comb begin
    hex_ok = 1'b1;
    hex_val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      hex_val = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      hex_val = 4'(c - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    logic [2:0] nb;
    logic       is_end;
    logic [MaxRun-1:0][7:0] bytes;
    logic       do_normal;
    nb = 3'd0;
    is_end = 1'b0;
    bytes = '0;
    do_normal = 1'b0;
    phase_d = phase_q;
    digits_d = digits_q;
    accum_d = accum_q;

    case (phase_q)
      PH_ESC: begin
        phase_d = PH_NORMAL;
        case (c)
          ChNul: begin
            bytes[0] = ChBslash;
            nb = 3'd1;
            is_end = 1'b1;
            digits_d = 2'd0;
            accum_d = '0;
          end
          ChQuote, ChBslash, ChSlash: begin
            bytes[0] = c;
            nb = 3'd1;
          end
          ChB: begin bytes[0] = CtlBs; nb = 3'd1; end
          ChF: begin bytes[0] = CtlFf; nb = 3'd1; end
          ChN: begin bytes[0] = CtlLf; nb = 3'd1; end
          ChR: begin bytes[0] = CtlCr; nb = 3'd1; end
          ChT: begin bytes[0] = CtlTab; nb = 3'd1; end
          ChU: begin
            phase_d = PH_HEX;
            digits_d = 2'd0;
            accum_d = '0;
          end
          default: begin
            bytes[0] = ChBslash;
            bytes[1] = c;
            nb = 3'd2;
          end
        endcase
      end
      PH_HEX: begin
        if (hex_ok) begin
          if (digits_q == 2'd3) begin
            if (cp <= Utf8Max1) begin
              bytes[0] = cp[7:0];
              nb = 3'd1;
            end else if (cp <= Utf8Max2) begin
              bytes[0] = Utf8Lead2 | {3'b000, cp[10:6]};
              bytes[1] = Utf8Cont | {2'b00, cp[5:0] & Utf8Mask};
              nb = 3'd2;
            end else begin
              bytes[0] = Utf8Lead3 | {4'b0000, cp[15:12]};
              bytes[1] = Utf8Cont | {2'b00, cp[11:6] & Utf8Mask};
              bytes[2] = Utf8Cont | {2'b00, cp[5:0] & Utf8Mask};
              nb = 3'd3;
            end
            phase_d = PH_NORMAL;
            digits_d = 2'd0;
            accum_d = '0;
          end else begin
            digits_d = digits_q + 2'd1;
            accum_d = cp;
          end
        end else begin
          bytes[0] = ChBslash;
          bytes[1] = ChU;
          nb = 3'd2;
          for (int k = 0; k < 3; k++) begin
            if (k < int'(digits_q)) begin
              bytes[nb] = held_q[k];
              nb = nb + 3'd1;
            end
          end
          phase_d = PH_NORMAL;
          digits_d = 2'd0;
          accum_d = '0;
          do_normal = 1'b1;
        end
      end
      default: begin
        phase_d = PH_NORMAL;
        do_normal = 1'b1;
      end
    endcase

    if (do_normal) begin
      if (c == ChNul || c == ChQuote) begin
        is_end = 1'b1;
        phase_d = PH_NORMAL;
        digits_d = 2'd0;
        accum_d = '0;
      end else if (c == ChBslash) begin
        phase_d = PH_ESC;
      end else begin
        bytes[nb] = c;
        nb = nb + 3'd1;
      end
    end

    run_o.cnt = nb + {2'b00, is_end};
    run_o.is_end = is_end;
    run_o.bytes = bytes;
  end

  assign push_o = accept & (run_o.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      digits_q <= 2'd0;
      accum_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      digits_q <= digits_d;
      accum_q <= accum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PH_HEX && hex_ok && digits_q != 2'd3) begin
      held_q[digits_q] <= c;
    end
  end

endmodule

// ----- hw/rtl/jsu_queue.sv -----
// Short queue of result runs between the front end and the back end.
`timescale 1ns / 1ps

module jsu_queue
  import jsu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t run_i,
  output logic full_o,
  output logic head_valid_o,
  output run_t head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  run_t [QueueDepth-1:0] slots_q;
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = (cnt_q == CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= run_i;
    end
  end

endmodule

// ----- hw/rtl/jsu_back.sv -----
// Back end: walks the head run one result per cycle, while the output is ready, into a registered output stage.
`timescale 1ns / 1ps

module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  run_t       head_i,
  output logic       pop_o,
  jsu_out_if.source  out_ch_o
);

  logic [2:0] idx_q;
  logic       valid_q;
  logic [7:0] data_q;
  logic       has_q, end_q, last_q;
  logic       load;
  logic       last;
  logic       marker;

  assign load = head_valid_i & (~valid_q | out_ch_o.ready);
  assign last = (idx_q == head_i.cnt - 3'd1);
  assign marker = last & head_i.is_end;
  assign pop_o = load & last;

  assign out_ch_o.valid = valid_q;
  assign out_ch_o.data_byte = data_q;
  assign out_ch_o.has_byte = has_q;
  assign out_ch_o.string_end = end_q;
  assign out_ch_o.last_of_run = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q <= last ? 3'd0 : idx_q + 3'd1;
      end else if (out_ch_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= marker ? 8'h00 : head_i.bytes[idx_q];
      has_q <= ~marker;
      end_q <= marker;
      last_q <= last;
    end
  end

endmodule

// ----- hw/rtl/json_string_unescape.sv -----
// Top level of the JSON string unescaper: front end, run queue and back end.
// A byte's run is stored in the run queue, then its first result in the output stage.
// Throughput: one byte per cycle while the output is ready and each byte yields at most
// one result; the back end emits a byte's results one at a time, and the four-entry run
// queue lets the front keep accepting meanwhile. Reset clears the escape state, the queue
// pointers and the output valid; the held hex digit characters are not reset.
`timescale 1ns / 1ps

module json_string_unescape
  import jsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_ch_i,
  jsu_out_if.source out_ch_o
);

  logic push;
  logic full;
  logic head_valid;
  logic pop;
  run_t run;
  run_t head;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch_i),
    .q_full_i (full),
    .push_o   (push),
    .run_o    (run)
  );

  jsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .run_i        (run),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_ch_o     (out_ch_o)
  );

endmodule
